FILE: rtl/mmp2_pkg.sv
// ----------------------------------------------------------------------------
// mmp2_pkg: shared types and constants for the 2x2 modular matrix power
// prime modulus, barrett reciprocal, matrix type and sequencer codes
// ----------------------------------------------------------------------------
package mmp2_pkg;

  localparam int unsigned ENTRY_W = 30;
  localparam int unsigned EXP_W   = 63;
  localparam int unsigned MUL_W   = 32;

  // prime modulus at entry width and at multiplier width
  localparam logic [ENTRY_W-1:0] MODULUS     = 30'd1000000007;
  localparam logic [MUL_W-1:0]   MODULUS_W   = 32'd1000000007;
  localparam logic [MUL_W-1:0]   TWO_MODULUS = 32'd2000000014;

  // floor(2^61 / modulus), fits in 32 bits
  localparam logic [63:0]      MU_FULL = 64'h2000000000000000 / 64'd1000000007;
  localparam logic [MUL_W-1:0] MU      = MU_FULL[MUL_W-1:0];

  typedef struct packed {
    logic [ENTRY_W-1:0] e00;
    logic [ENTRY_W-1:0] e01;
    logic [ENTRY_W-1:0] e10;
    logic [ENTRY_W-1:0] e11;
  } mat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BIT,
    ST_MUL
  } state_t;

  typedef enum logic [2:0] {
    PH_T0,
    PH_T1,
    PH_SUM,
    PH_QEST,
    PH_QP,
    PH_FIX
  } phase_t;

  typedef enum logic {
    OP_ACC,
    OP_SQR
  } op_t;

endpackage

FILE: rtl/modular_matrix_power_2x2.sv
// ----------------------------------------------------------------------------
// modular_matrix_power_2x2: 2x2 matrix power modulo 1000000007
// square-and-multiply over the exponent bits on one shared 32x32 multiplier
// ----------------------------------------------------------------------------
// one squaring per significant exponent bit and one multiply per set bit;
//   no product at all for a zero exponent
// each matrix product takes its 4 entries in turn on the single 32x32 multiplier,
//   each through phases T0, T1, SUM, QEST, QP and FIX, after one decision state
// one item at a time; the next item is taken the cycle after the result is
//   loaded into the output register, even while that result is still stalled
// rst clears the sequencer and the output valid; payload registers are not reset
// ----------------------------------------------------------------------------
module modular_matrix_power_2x2 (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mmp2_pkg::EXP_W-1:0]     exponent,
  input  logic [mmp2_pkg::ENTRY_W-1:0]   base_a00,
  input  logic [mmp2_pkg::ENTRY_W-1:0]   base_a01,
  input  logic [mmp2_pkg::ENTRY_W-1:0]   base_a10,
  input  logic [mmp2_pkg::ENTRY_W-1:0]   base_a11,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mmp2_pkg::ENTRY_W-1:0]   pow_r00,
  output logic [mmp2_pkg::ENTRY_W-1:0]   pow_r01,
  output logic [mmp2_pkg::ENTRY_W-1:0]   pow_r10,
  output logic [mmp2_pkg::ENTRY_W-1:0]   pow_r11
);
  import mmp2_pkg::*;

  // entry k = {row, col}
  function automatic logic [ENTRY_W-1:0] get_entry(mat_t m, logic [1:0] k);
    logic [ENTRY_W-1:0] v;
    case (k)
      2'd0:    v = m.e00;
      2'd1:    v = m.e01;
      2'd2:    v = m.e10;
      default: v = m.e11;
    endcase
    return v;
  endfunction

  function automatic mat_t set_entry(mat_t m, logic [1:0] k, logic [ENTRY_W-1:0] v);
    mat_t r;
    r = m;
    case (k)
      2'd0:    r.e00 = v;
      2'd1:    r.e01 = v;
      2'd2:    r.e10 = v;
      default: r.e11 = v;
    endcase
    return r;
  endfunction

  // raw 30-bit input is below twice the modulus: one conditional subtract
  function automatic logic [ENTRY_W-1:0] fold(logic [ENTRY_W-1:0] v);
    return (v >= MODULUS) ? (v - MODULUS) : v;
  endfunction

  // sequencer
  state_t state, state_next;
  phase_t phase;
  logic [1:0] entry;
  op_t op;

  // operands and partial results
  mat_t base;
  mat_t accm;
  mat_t tmp;
  logic [EXP_W-1:0] exp_rem;

  // shared multiplier and reduction path
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;
  logic [60:0]        sum;
  logic [MUL_W-1:0]   diff, red_w;
  logic [ENTRY_W-1:0] red;
  logic [ENTRY_W-1:0] x0, x1, y0, y1;
  mat_t lhs;
  mat_t new_m;

  logic take_in;
  logic load_out;
  logic last_fix;

  assign take_in  = (state == ST_IDLE) && in_valid;
  assign load_out = (state == ST_BIT) && (exp_rem == '0) && (!out_valid || !out_stall);
  assign last_fix = (state == ST_MUL) && (phase == PH_FIX) && (entry == 2'd3);
  assign in_stall = (state != ST_IDLE);

  // left operand is the running power for the multiply step, else the base
  assign lhs = (op == OP_SQR) ? base : accm;
  assign x0  = get_entry(lhs, {entry[1], 1'b0});
  assign x1  = get_entry(lhs, {entry[1], 1'b1});
  assign y0  = get_entry(base, {1'b0, entry[0]});
  assign y1  = get_entry(base, {1'b1, entry[0]});

  // operand select for the one multiplier
  always_comb begin
    case (phase)
      PH_T0: begin
        mul_a = {2'b00, x0};
        mul_b = {2'b00, y0};
      end
      PH_T1: begin
        mul_a = {2'b00, x1};
        mul_b = {2'b00, y1};
      end
      PH_QEST: begin
        // top 32 bits of the sum times the reciprocal
        mul_a = sum[60:29];
        mul_b = MU;
      end
      PH_QP: begin
        // quotient estimate times the modulus
        mul_a = prod[63:32];
        mul_b = MODULUS_W;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // quotient estimate is at most 2 low, so the remainder is below 3 * modulus
  // and fits in 32 bits; two compares bring it below the modulus
  always_comb begin
    diff = sum[31:0] - prod[31:0];
    if (diff >= TWO_MODULUS) begin
      red_w = diff - TWO_MODULUS;
    end else if (diff >= MODULUS_W) begin
      red_w = diff - MODULUS_W;
    end else begin
      red_w = diff;
    end
    red   = red_w[ENTRY_W-1:0];
    new_m = set_entry(tmp, entry, red);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_BIT;
        end
      end
      ST_BIT: begin
        // exponent used up: hand the result over once the output register is free
        if (exp_rem == '0) begin
          if (load_out) begin
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (last_fix) begin
          state_next = ST_BIT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_T0;
      entry <= '0;
      op    <= OP_ACC;
    end else if (state == ST_BIT) begin
      phase <= PH_T0;
      entry <= '0;
      // set low bit: multiply into the running power first, then square
      op    <= exp_rem[0] ? OP_ACC : OP_SQR;
    end else if (state == ST_MUL) begin
      case (phase)
        PH_T0:   phase <= PH_T1;
        PH_T1:   phase <= PH_SUM;
        PH_SUM:  phase <= PH_QEST;
        PH_QEST: phase <= PH_QP;
        PH_QP:   phase <= PH_FIX;
        default: begin
          phase <= PH_T0;
          entry <= entry + 2'd1;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);

    if (state == ST_MUL) begin
      if (phase == PH_T1) begin
        sum <= 61'(prod[59:0]);
      end else if (phase == PH_SUM) begin
        sum <= sum + 61'(prod[59:0]);
      end
      if (phase == PH_FIX) begin
        tmp <= new_m;
      end
    end

    if (take_in) begin
      exp_rem  <= exponent;
      base.e00 <= fold(base_a00);
      base.e01 <= fold(base_a01);
      base.e10 <= fold(base_a10);
      base.e11 <= fold(base_a11);
      accm.e00 <= ENTRY_W'(1);
      accm.e01 <= '0;
      accm.e10 <= '0;
      accm.e11 <= ENTRY_W'(1);
    end else if (last_fix) begin
      if (op == OP_ACC) begin
        // low bit consumed; the squaring for this bit follows
        accm       <= new_m;
        exp_rem[0] <= 1'b0;
      end else begin
        base    <= new_m;
        exp_rem <= exp_rem >> 1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pow_r00 <= accm.e00;
      pow_r01 <= accm.e01;
      pow_r10 <= accm.e10;
      pow_r11 <= accm.e11;
    end
  end

endmodule

FILE: verif/modular_matrix_power_2x2_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_matrix_power_2x2_tb: self-checking bench for the 2x2 matrix power
// drives base matrices and exponents through the valid/stall handshake, works
// out each power modulo 1000000007 by square-and-multiply in a scoreboard and
// compares every returned matrix entry by entry, in order
// ----------------------------------------------------------------------------
module modular_matrix_power_2x2_tb;

  import mmp2_pkg::*;

  // prime at full product width so every reduction is done in 64 bits
  localparam logic [63:0]        PRIME      = 64'd1000000007;
  localparam logic [ENTRY_W-1:0] PRIME_E    = 30'd1000000007;
  localparam logic [ENTRY_W-1:0] PRIME_M1   = 30'd1000000006;
  localparam logic [ENTRY_W-1:0] ENTRY_MAX  = {ENTRY_W{1'b1}};
  localparam logic [EXP_W-1:0]   EXP_MAX    = {EXP_W{1'b1}};

  localparam int RANDOM_ITEMS = 1580;
  localparam int MAX_GAP      = 12;
  // receiver hold-off long enough to fill the block and stall its input
  localparam int LONG_HOLD    = 2000;
  // cycles to keep watching after the last result
  localparam int DRAIN_CYCLES = 200;
  // long enough for the slowest item (all 63 exponent bits set), plus one
  // result parked in the output register and the sender and receiver gaps;
  // also covers the long receiver hold-off
  localparam int STALL_LIMIT  = 20000;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [EXP_W-1:0]    exponent;
  logic [ENTRY_W-1:0]  base_a00;
  logic [ENTRY_W-1:0]  base_a01;
  logic [ENTRY_W-1:0]  base_a10;
  logic [ENTRY_W-1:0]  base_a11;
  logic                out_valid;
  logic                out_stall;
  logic [ENTRY_W-1:0]  pow_r00;
  logic [ENTRY_W-1:0]  pow_r01;
  logic [ENTRY_W-1:0]  pow_r10;
  logic [ENTRY_W-1:0]  pow_r11;

  // idling controls for the sender and the receiver, set by the stimulus
  bit in_quiet     = 1'b0;
  bit out_quiet    = 1'b0;
  bit hold_results = 1'b0;

  int unsigned quiet_cycles;

  // --------------------------------------------------------------------------
  // expected matrix powers, oldest first
  // --------------------------------------------------------------------------
  class power_scoreboard;
    mat_t expected_powers[$];
    int   mismatches;

    function new();
      mismatches = 0;
    endfunction

    // one entry reduced below the prime
    function logic [ENTRY_W-1:0] reduce_entry(logic [ENTRY_W-1:0] v);
      logic [63:0] w;
      w = 64'(v) % PRIME;
      return w[ENTRY_W-1:0];
    endfunction

    // one entry of a product: exact sum of two 60-bit terms, then reduced
    function logic [ENTRY_W-1:0] mod_dot(logic [ENTRY_W-1:0] a, logic [ENTRY_W-1:0] b,
                                         logic [ENTRY_W-1:0] c, logic [ENTRY_W-1:0] d);
      logic [63:0] sum;
      sum = 64'(a) * 64'(b) + 64'(c) * 64'(d);
      sum = sum % PRIME;
      return sum[ENTRY_W-1:0];
    endfunction

    function mat_t mat_product(mat_t x, mat_t y);
      mat_t r;
      r.e00 = mod_dot(x.e00, y.e00, x.e01, y.e10);
      r.e01 = mod_dot(x.e00, y.e01, x.e01, y.e11);
      r.e10 = mod_dot(x.e10, y.e00, x.e11, y.e10);
      r.e11 = mod_dot(x.e10, y.e01, x.e11, y.e11);
      return r;
    endfunction

    // square-and-multiply, lowest exponent bit first; squaring past the top
    // set bit does not touch the running product
    function mat_t matrix_power_mod(logic [EXP_W-1:0] e, mat_t raw);
      mat_t sq;
      mat_t prod;
      sq.e00 = reduce_entry(raw.e00);
      sq.e01 = reduce_entry(raw.e01);
      sq.e10 = reduce_entry(raw.e10);
      sq.e11 = reduce_entry(raw.e11);
      prod   = {30'd1, 30'd0, 30'd0, 30'd1};
      for (int i = 0; i < EXP_W; i++) begin
        if (e[i]) prod = mat_product(prod, sq);
        sq = mat_product(sq, sq);
      end
      return prod;
    endfunction

    function void note_input(logic [EXP_W-1:0] e, mat_t raw);
      expected_powers = {expected_powers, matrix_power_mod(e, raw)};
    endfunction

    function void compare_entry(string name, logic [ENTRY_W-1:0] want,
                                logic [ENTRY_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(mat_t got);
      mat_t want;
      if (expected_powers.size() == 0) begin
        $display("%0t: unexpected result expected none got %0d %0d %0d %0d",
                 $time, got.e00, got.e01, got.e10, got.e11);
        mismatches++;
      end else begin
        want = expected_powers.pop_front();
        compare_entry("pow_r00", want.e00, got.e00);
        compare_entry("pow_r01", want.e01, got.e01);
        compare_entry("pow_r10", want.e10, got.e10);
        compare_entry("pow_r11", want.e11, got.e11);
      end
    endfunction

    function int outstanding();
      return expected_powers.size();
    endfunction
  endclass

  power_scoreboard sb = new();

  modular_matrix_power_2x2 uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .exponent  (exponent),
    .base_a00  (base_a00),
    .base_a01  (base_a01),
    .base_a10  (base_a10),
    .base_a11  (base_a11),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pow_r00   (pow_r00),
    .pow_r01   (pow_r01),
    .pow_r10   (pow_r10),
    .pow_r11   (pow_r11)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // handshake monitor: both channels sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      // check before noting, so a stray result never meets a fresh item
      if (out_valid && !out_stall)
        sb.check_result({pow_r00, pow_r01, pow_r10, pow_r11});
      if (in_valid && !in_stall)
        sb.note_input(exponent, {base_a00, base_a01, base_a10, base_a11});
    end
  end

  // watchdog: ends the run when no item moves on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: stalls a result for a random gap, which may be zero, once it shows,
  // and once on request holds everything off for a long stretch
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (hold_results) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_results = 1'b0;
      end
      gap = out_quiet ? 0 : $urandom_range(0, MAX_GAP);
      out_stall <= (gap != 0);
      do @(posedge clk); while (!out_valid);
      if (gap != 0) begin
        // result is showing but held off
        repeat (gap - 1) @(posedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // sender: random gap, then offer the item until it is taken; valid stays
  // high straight into the next item when the gap is zero
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [EXP_W-1:0] e, input mat_t m);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    exponent <= e;
    base_a00 <= m.e00;
    base_a01 <= m.e01;
    base_a10 <= m.e10;
    base_a11 <= m.e11;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // sender goes idle until every expected matrix has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
  endtask

  // entries mostly in range, with zero, one, prime - 1 and values at or above
  // the prime mixed in
  function automatic logic [ENTRY_W-1:0] random_entry();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return 30'd1;
      2:       return PRIME_M1;
      3:       return ENTRY_W'($urandom_range(PRIME_E, ENTRY_MAX));
      default: return ENTRY_W'($urandom_range(0, PRIME_M1));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int               pick;
    logic [63:0]      raw;
    logic [EXP_W-1:0] e;

    rst      = 1'b1;
    in_valid = 1'b0;
    exponent = '0;
    base_a00 = '0;
    base_a01 = '0;
    base_a10 = '0;
    base_a11 = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // zero exponent gives identity, whatever the base
    send_item('0, {30'd123456789, 30'd987654321, 30'd555, PRIME_M1});
    send_item('0, {ENTRY_MAX, ENTRY_MAX, ENTRY_MAX, ENTRY_MAX});
    // largest in-range entries, and entries at or above the prime
    send_item(63'd1, {PRIME_M1, PRIME_M1, PRIME_M1, PRIME_M1});
    send_item(63'd1, {PRIME_E, ENTRY_MAX, PRIME_E + 30'd1, 30'd0});
    send_item(63'd2, {ENTRY_MAX, ENTRY_MAX, ENTRY_MAX, ENTRY_MAX});
    send_item(63'd1, {30'd536870912, 30'd357913941, 30'd715827882, 30'd0});
    // zero and identity bases
    send_item(63'd5, {30'd0, 30'd0, 30'd0, 30'd0});
    send_item(63'd3, {30'd1, 30'd0, 30'd0, 30'd1});
    // fibonacci matrix, small and full exponents
    send_item(63'd10, {30'd1, 30'd1, 30'd1, 30'd0});
    send_item(63'd90, {30'd1, 30'd1, 30'd1, 30'd0});
    send_item(EXP_MAX, {30'd1, 30'd1, 30'd1, 30'd0});
    // full exponent on identity and on minus identity
    send_item(EXP_MAX, {30'd1, 30'd0, 30'd0, 30'd1});
    send_item(EXP_MAX, {PRIME_M1, 30'd0, 30'd0, PRIME_M1});
    // only the top exponent bit
    send_item({1'b1, {(EXP_W-1){1'b0}}}, {30'd2, 30'd0, 30'd0, 30'd3});
    // alternating exponent bits, both phases
    send_item({{31{2'b10}}, 1'b1}, {30'd1, 30'd2, 30'd3, 30'd4});
    send_item({{31{2'b01}}, 1'b0}, {PRIME_M1, 30'd1, PRIME_M1, 30'd1});
    send_item(63'd1000000006, {30'd2, 30'd1, 30'd1, 30'd1});
    send_item(63'hFFFF_FFFF, {ENTRY_MAX, PRIME_E, 30'd1, 30'd0});
    wait_drained();

    // random part: mostly short exponents, some mid-size, a few full width
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        in_quiet  = ($urandom_range(0, 3) == 0);
        out_quiet = ($urandom_range(0, 3) == 0);
      end
      // long receiver hold-off while items keep coming
      if (n == 250) hold_results = 1'b1;
      if (n == 600 || n == 1200) wait_drained();
      pick = $urandom_range(0, 99);
      raw  = {$urandom, $urandom};
      if (pick < 5)
        e = raw[EXP_W-1:0];
      else if (pick < 25)
        e = raw[EXP_W-1:0] >> (EXP_W - $urandom_range(0, 24));
      else
        e = raw[EXP_W-1:0] >> (EXP_W - $urandom_range(0, 10));
      send_item(e, {random_entry(), random_entry(), random_entry(), random_entry()});
    end

    wait_drained();
    // watch a little longer for any stray result
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
